### rtl/sir_pkg.sv
// Shared types, constants and bit-shuffle functions for the syncpoint interrupt router.
package sir_pkg;

    localparam int NUM_SYNCPTS  = 32;
    localparam int HALF_SYNCPTS = NUM_SYNCPTS / 2;
    localparam int OP_W         = 3;
    localparam int ID_W         = $clog2(NUM_SYNCPTS);

    // Operation codes carried in the low bits of s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_ENABLE     = 3'd0,
        OP_SET_DEST   = 3'd1,
        OP_CLEAR_DEST = 3'd2,
        OP_FIRE       = 3'd3,
        OP_CLEAR_STAT = 3'd4,
        OP_READ       = 3'd5
    } op_t;

    typedef logic [NUM_SYNCPTS-1:0] sp_mask_t;

    // Routing state, pending state and interrupt lines of both processors
    typedef struct packed {
        logic [1:0] line;
        sp_mask_t   pend_cpu;
        sp_mask_t   pend_cop;
        sp_mask_t   route_cpu;
        sp_mask_t   route_cop;
    } irq_state_t;

    // Pick processor c's bits out of an interleaved word (bit 2i+c -> bit i)
    function automatic logic [HALF_SYNCPTS-1:0] deinterleave(input sp_mask_t word,
                                                             input logic c);
        logic [HALF_SYNCPTS-1:0] r;
        r = '0;
        for (int i = 0; i < HALF_SYNCPTS; i++) begin
            r[i] = word[2*i + int'(c)];
        end
        return r;
    endfunction

    // Merge two half masks into one interleaved word (bit i of c -> bit 2i+c)
    function automatic sp_mask_t interleave(input logic [HALF_SYNCPTS-1:0] cpu_half,
                                            input logic [HALF_SYNCPTS-1:0] cop_half);
        sp_mask_t r;
        r = '0;
        for (int i = 0; i < HALF_SYNCPTS; i++) begin
            r[2*i]     = cpu_half[i];
            r[2*i + 1] = cop_half[i];
        end
        return r;
    endfunction

endpackage

### rtl/sir_core.sv
// Next-state logic of the router: applies one operation to the routing and status state.
module sir_core (
    input  logic [sir_pkg::OP_W-1:0] op,
    input  logic                     cpu_sel,
    input  sir_pkg::sp_mask_t        mask,
    input  logic                     part,
    input  logic [sir_pkg::ID_W-1:0] fire_id,
    input  sir_pkg::sp_mask_t        crossed,
    input  sir_pkg::irq_state_t      cur,
    output sir_pkg::irq_state_t      nxt
);
    import sir_pkg::*;

    sp_mask_t                route [2];
    sp_mask_t                pend  [2];
    sp_mask_t                route_new [2];
    sp_mask_t                pend_new  [2];
    logic [1:0]              line_new;
    sp_mask_t                add;
    sp_mask_t                fire_bit;
    sp_mask_t                keep;
    sp_mask_t                pend_cleared;
    logic [HALF_SYNCPTS-1:0] dest_half [2];

    assign route[0] = cur.route_cpu;
    assign route[1] = cur.route_cop;
    assign pend[0]  = cur.pend_cpu;
    assign pend[1]  = cur.pend_cop;

    assign add          = mask & crossed;
    assign fire_bit     = sp_mask_t'(1) << fire_id;
    assign keep         = mask & route[cpu_sel] & crossed;
    assign pend_cleared = pend[cpu_sel] & ~(mask & ~keep);
    assign dest_half[0] = deinterleave(mask, 1'b0);
    assign dest_half[1] = deinterleave(mask, 1'b1);

    // Apply the operation; unused codes leave the state as it is
    always_comb begin
        route_new[0] = route[0];
        route_new[1] = route[1];
        pend_new[0]  = pend[0];
        pend_new[1]  = pend[1];
        line_new     = cur.line;
        case (op_t'(op))
            OP_ENABLE: begin
                route_new[cpu_sel]  = route[cpu_sel] | mask;
                route_new[~cpu_sel] = route[~cpu_sel] & ~mask;
                if (|add) begin
                    pend_new[cpu_sel] = pend[cpu_sel] | add;
                    line_new[cpu_sel] = 1'b1;
                end
            end
            OP_SET_DEST: begin
                for (int c = 0; c < 2; c++) begin
                    if (part) begin
                        route_new[c] = route[c] | {dest_half[c], {HALF_SYNCPTS{1'b0}}};
                    end else begin
                        route_new[c] = route[c] | {{HALF_SYNCPTS{1'b0}}, dest_half[c]};
                    end
                end
            end
            OP_CLEAR_DEST: begin
                route_new[0] = route[0] & ~mask;
                route_new[1] = route[1] & ~mask;
            end
            OP_FIRE: begin
                for (int c = 0; c < 2; c++) begin
                    if (|(route[c] & fire_bit)) begin
                        pend_new[c] = pend[c] | fire_bit;
                        line_new[c] = 1'b1;
                    end
                end
            end
            OP_CLEAR_STAT: begin
                pend_new[cpu_sel] = pend_cleared;
                if (pend_cleared == '0) begin
                    line_new[cpu_sel] = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign nxt.line      = line_new;
    assign nxt.pend_cpu  = pend_new[0];
    assign nxt.pend_cop  = pend_new[1];
    assign nxt.route_cpu = route_new[0];
    assign nxt.route_cop = route_new[1];

endmodule

### rtl/syncpoint_irq_router.sv
// Top level of the syncpoint interrupt router: input register, state, result register.
// A word accepted at s_ is held in the input register, then loaded into the result register and presented on m_.
// Throughput: one word per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset (aresetn low, synchronous) clears routing, pending status, both lines
// and both valid flags; no clearing pass is needed.
module syncpoint_irq_router (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mask[31:0], fire_id[36:32], crossed[68:37], zero pad [71:69]
    input  logic [71:0]  s_tdata,
    // op[2:0], cpu_sel[3], part[4]
    input  logic [4:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // cpu_status[31:0], cop_status[63:32], summary_status[65:64],
    // dest_low[97:66], dest_high[129:98], zero pad [135:130]
    output logic [135:0] m_tdata
);
    import sir_pkg::*;

    logic                 in_valid_reg;
    logic [OP_W-1:0]      op_reg;
    logic                 cpu_sel_reg;
    sp_mask_t             mask_reg;
    logic                 part_reg;
    logic [ID_W-1:0]      id_reg;
    sp_mask_t             crossed_reg;
    irq_state_t           state_reg;
    irq_state_t           state_next;
    logic                 out_valid_reg;
    logic [135:0]         out_data_reg;
    logic [135:0]         out_data_next;
    logic                 advance;
    logic                 s_accept;

    assign advance  = ~out_valid_reg | m_tready;
    assign s_tready = ~in_valid_reg | advance;
    assign s_accept = s_tvalid & s_tready;

    // Hold the incoming word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_accept) begin
            op_reg      <= s_tuser[2:0];
            cpu_sel_reg <= s_tuser[3];
            part_reg    <= s_tuser[4];
            mask_reg    <= s_tdata[31:0];
            id_reg      <= s_tdata[36:32];
            crossed_reg <= s_tdata[68:37];
        end
    end

    sir_core u_core (
        .op        (op_reg),
        .cpu_sel   (cpu_sel_reg),
        .mask      (mask_reg),
        .part      (part_reg),
        .fire_id   (id_reg),
        .crossed   (crossed_reg),
        .cur       (state_reg),
        .nxt       (state_next)
    );

    // Format the result word from the updated state
    assign out_data_next = {
        6'd0,
        interleave(state_next.route_cpu[NUM_SYNCPTS-1:HALF_SYNCPTS],
                   state_next.route_cop[NUM_SYNCPTS-1:HALF_SYNCPTS]),
        interleave(state_next.route_cpu[HALF_SYNCPTS-1:0],
                   state_next.route_cop[HALF_SYNCPTS-1:0]),
        state_next.line,
        state_next.pend_cop,
        state_next.pend_cpu
    };

    // Commit the state and load the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                state_reg <= state_next;
            end
        end
        if (advance && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    // A line is high exactly while its processor has pending bits
    a_cpu_line: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.line[0] == (|state_reg.pend_cpu))
        else $error("CPU line disagrees with pending status");

    a_cop_line: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.line[1] == (|state_reg.pend_cop))
        else $error("COP line disagrees with pending status");

    // A presented result carries lines consistent with its status words
    a_out_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[64] == (|m_tdata[31:0])) && (m_tdata[65] == (|m_tdata[63:32])))
        else $error("result summary disagrees with status words");

    // A held word that advances shows up as a result next cycle
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && advance) |=> out_valid_reg)
        else $error("advanced word did not reach the result register");
`endif

endmodule

### tb/sv/tb_syncpoint_irq_router.sv
// Self-checking testbench for the syncpoint interrupt router stream block.
module tb_syncpoint_irq_router;
    timeunit 1ns;
    timeprecision 1ps;

    import sir_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 4;

    // Op codes the block treats as read only
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    // One status snapshot as the block reports it
    typedef struct {
        sp_mask_t   cpu_status;
        sp_mask_t   cop_status;
        logic [1:0] lines;
        sp_mask_t   dest_low;
        sp_mask_t   dest_high;
    } irq_snapshot_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic [4:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;

    // Predicted router state
    sp_mask_t   pend_word[2] = '{default: '0};
    sp_mask_t   route_word[2] = '{default: '0};
    logic [1:0] line_bits = 2'b00;

    irq_snapshot_t snapshots_due[$];

    int  mismatch_count = 0;
    int  snapshots_checked = 0;
    int  words_sent = 0;
    int  op_count[8] = '{default: 0};
    int  cycle_count = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  stall_left = 0;

    syncpoint_irq_router uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d snapshots still due",
                     cycle_count, snapshots_due.size());
            $display("tb_syncpoint_irq_router: FAIL");
            $finish;
        end
    end

    // Apply one operation to the predicted state and return the snapshot after it
    function automatic irq_snapshot_t apply_irq_op(input logic [OP_W-1:0] op,
                                                   input logic sel,
                                                   input sp_mask_t mask,
                                                   input logic part,
                                                   input logic [ID_W-1:0] id,
                                                   input sp_mask_t crossed);
        irq_snapshot_t snap;
        sp_mask_t      gain;
        sp_mask_t      keep;
        int            sp;
        case (op)
            OP_ENABLE: begin
                route_word[sel] |= mask;
                route_word[sel ^ 1'b1] &= ~mask;
                gain = mask & crossed;
                if (gain != '0) begin
                    pend_word[sel] |= gain;
                    line_bits[sel] = 1'b1;
                end
            end
            OP_SET_DEST: begin
                // even bits route to CPU, odd bits to COP
                for (int j = 0; j < NUM_SYNCPTS; j++) begin
                    if (mask[j]) begin
                        sp = j / 2 + (part ? HALF_SYNCPTS : 0);
                        route_word[j % 2][sp] = 1'b1;
                    end
                end
            end
            OP_CLEAR_DEST: begin
                route_word[0] &= ~mask;
                route_word[1] &= ~mask;
            end
            OP_FIRE: begin
                for (int c = 0; c < 2; c++) begin
                    if (route_word[c][id]) begin
                        pend_word[c][id] = 1'b1;
                        line_bits[c] = 1'b1;
                    end
                end
            end
            OP_CLEAR_STAT: begin
                // routed and still crossed bits survive the clear
                keep = mask & route_word[sel] & crossed;
                pend_word[sel] &= ~(mask & ~keep);
                if (pend_word[sel] == '0) begin
                    line_bits[sel] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        snap.cpu_status = pend_word[0];
        snap.cop_status = pend_word[1];
        snap.lines      = line_bits;
        for (int i = 0; i < HALF_SYNCPTS; i++) begin
            for (int c = 0; c < 2; c++) begin
                snap.dest_low[2*i + c]  = route_word[c][i];
                snap.dest_high[2*i + c] = route_word[c][i + HALF_SYNCPTS];
            end
        end
        return snap;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s at result %0d: got %h, want %h",
                 field, snapshots_checked, got, want);
        mismatch_count++;
    endtask

    // Compare one result word against the oldest predicted snapshot
    task automatic check_snapshot(input logic [135:0] word);
        irq_snapshot_t want;
        if (snapshots_due.size() == 0) begin
            report_mismatch("unexpected result", word[31:0], '0);
        end else begin
            want = snapshots_due.pop_front();
            if (word[31:0] !== want.cpu_status)
                report_mismatch("cpu_status", word[31:0], want.cpu_status);
            if (word[63:32] !== want.cop_status)
                report_mismatch("cop_status", word[63:32], want.cop_status);
            if (word[65:64] !== want.lines)
                report_mismatch("summary_status", 32'(word[65:64]), 32'(want.lines));
            if (word[97:66] !== want.dest_low)
                report_mismatch("dest_low", word[97:66], want.dest_low);
            if (word[129:98] !== want.dest_high)
                report_mismatch("dest_high", word[129:98], want.dest_high);
        end
        snapshots_checked++;
    endtask

    // Take results and drive m_tready: long hold-off, random stall bursts, or ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_snapshot(m_tdata);
        end
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offer one word and hold it until accepted, then record its prediction
    task automatic send_word(input logic [OP_W-1:0] op, input logic sel,
                             input sp_mask_t mask, input logic part,
                             input logic [ID_W-1:0] id, input sp_mask_t crossed);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, crossed, id, mask};
        s_tuser  <= {part, sel, op};
        do @(posedge aclk); while (!s_tready);
        snapshots_due.push_back(apply_irq_op(op, sel, mask, part, id, crossed));
        op_count[op]++;
        words_sent++;
    endtask

    // Drop valid for a random burst now and then
    task automatic sender_pause();
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    function automatic sp_mask_t rand_mask();
        case ($urandom_range(0, 5))
            0: return sp_mask_t'(1) << $urandom_range(0, NUM_SYNCPTS - 1);
            1: return '1;
            2: return $urandom & $urandom;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Favor syncpoints that are routed somewhere so that fires land
    function automatic logic [ID_W-1:0] rand_id();
        sp_mask_t         routed;
        logic [ID_W-1:0]  id;
        routed = route_word[0] | route_word[1];
        id = ID_W'($urandom_range(0, NUM_SYNCPTS - 1));
        if (routed != '0 && $urandom_range(0, 2) != 0) begin
            while (!routed[id]) id = ID_W'($urandom_range(0, NUM_SYNCPTS - 1));
        end
        return id;
    endfunction

    function automatic logic [OP_W-1:0] rand_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return OP_ENABLE;
        if (roll < 25) return OP_SET_DEST;
        if (roll < 33) return OP_CLEAR_DEST;
        if (roll < 63) return OP_FIRE;
        if (roll < 85) return OP_CLEAR_STAT;
        if (roll < 93) return OP_READ;
        if (roll < 97) return OP_SPARE_6;
        return OP_SPARE_7;
    endfunction

    task automatic send_random_word();
        send_word(rand_op(), 1'($urandom), rand_mask(), 1'($urandom), rand_id(),
                  $urandom_range(0, 3) == 0 ? rand_mask() : sp_mask_t'($urandom));
    endtask

    // Walk through every op and the corner cases of routing and clearing
    task automatic test_directed_ops();
        send_word(OP_READ,       1'b0, '0,            1'b0, 5'd0,  '0);
        send_word(OP_FIRE,       1'b0, '0,            1'b0, 5'd0,  '0);
        send_word(OP_ENABLE,     1'b0, '1,            1'b0, 5'd0,  '0);
        // move syncpoints 0 and 31 to COP, 31 already crossed
        send_word(OP_ENABLE,     1'b1, 32'h8000_0001, 1'b0, 5'd0,  32'h8000_0000);
        send_word(OP_FIRE,       1'b0, '0,            1'b0, 5'd31, '0);
        send_word(OP_FIRE,       1'b1, '0,            1'b0, 5'd0,  '0);
        send_word(OP_FIRE,       1'b0, '0,            1'b0, 5'd5,  '0);
        send_word(OP_SET_DEST,   1'b0, '1,            1'b0, 5'd0,  '0);
        send_word(OP_SET_DEST,   1'b1, 32'hAAAA_AAAA, 1'b1, 5'd0,  '0);
        send_word(OP_FIRE,       1'b0, '0,            1'b0, 5'd16, '0);
        // routed and crossed bits are kept
        send_word(OP_CLEAR_STAT, 1'b0, '1,            1'b0, 5'd0,  '1);
        // full clear drops the CPU line
        send_word(OP_CLEAR_STAT, 1'b0, '1,            1'b0, 5'd0,  '0);
        // partial clear leaves the COP line up
        send_word(OP_CLEAR_STAT, 1'b1, 32'h0000_0001, 1'b0, 5'd0,  '0);
        send_word(OP_CLEAR_DEST, 1'b0, '1,            1'b0, 5'd0,  '0);
        send_word(OP_FIRE,       1'b1, '0,            1'b0, 5'd31, '1);
        // nothing routed, so nothing is kept
        send_word(OP_CLEAR_STAT, 1'b1, '1,            1'b0, 5'd0,  '1);
        send_word(OP_SET_DEST,   1'b0, 32'h5555_5555, 1'b1, 5'd0,  '0);
        send_word(OP_ENABLE,     1'b1, '0,            1'b0, 5'd0,  '1);
        send_word(OP_ENABLE,     1'b0, 32'h0000_FFFF, 1'b0, 5'd0,  '1);
        send_word(OP_CLEAR_STAT, 1'b0, '0,            1'b0, 5'd0,  '0);
        send_word(OP_SPARE_6,    1'b1, '1,            1'b1, 5'd31, '1);
        send_word(OP_SPARE_7,    1'b0, 32'h1234_5678, 1'b1, 5'd7,  '1);
        // clearing an empty word keeps the line low
        send_word(OP_CLEAR_STAT, 1'b1, '1,            1'b1, 5'd0,  '0);
        send_word(OP_READ,       1'b1, '1,            1'b1, 5'd31, '1);
    endtask

    // Random traffic with idling on both sides, receiver idling toggled in stretches
    task automatic test_random_traffic(input int n);
        for (int k = 0; k < n; k++) begin
            if (k % 100 == 0) rx_idle_en = (k / 100) % 3 != 2;
            send_random_word();
            sender_pause();
        end
        rx_idle_en = 1'b1;
    endtask

    // Hold the receiver off while the sender keeps offering, so the input stalls
    task automatic test_backpressure(input int n);
        tx_idle_en = 1'b0;
        hold_req++;
        for (int k = 0; k < n; k++) begin
            send_random_word();
        end
        tx_idle_en = 1'b1;
    endtask

    // Back-to-back words with no idling on either side
    task automatic test_full_rate(input int n);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int k = 0; k < n; k++) begin
            send_random_word();
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_ops();
        sender_pause();
        test_random_traffic(450);
        test_backpressure(40);
        test_full_rate(190);
        s_tvalid <= 1'b0;
        while (snapshots_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("sent %0d words (enable %0d, set dest %0d, clear dest %0d, fire %0d,",
                 words_sent, op_count[OP_ENABLE], op_count[OP_SET_DEST],
                 op_count[OP_CLEAR_DEST], op_count[OP_FIRE]);
        $display("clear status %0d, read %0d, spare %0d); %0d results checked",
                 op_count[OP_CLEAR_STAT], op_count[OP_READ],
                 op_count[OP_SPARE_6] + op_count[OP_SPARE_7], snapshots_checked);
        if (mismatch_count == 0) begin
            $display("tb_syncpoint_irq_router: PASS");
        end else begin
            $display("tb_syncpoint_irq_router: FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/sir_pkg.sv
rtl/sir_core.sv
rtl/syncpoint_irq_router.sv
tb/sv/tb_syncpoint_irq_router.sv
